[hw/rtl/spl_pkg.sv]
// ----------------------------------------------------------------------------
// spl_pkg: shared definitions for the sorted priority list
// Operation and status codes, the entry and control types, and list sizes.
// ----------------------------------------------------------------------------
package spl_pkg;

  localparam int Capacity = 16;

  localparam int KeyWidth  = 32;
  localparam int ItemWidth = 32;

  localparam logic [2:0] OP_INSERT      = 3'd0;
  localparam logic [2:0] OP_REMOVE_HEAD = 3'd1;
  localparam logic [2:0] OP_REMOVE_KEY  = 3'd2;
  localparam logic [2:0] OP_PREPEND     = 3'd3;
  localparam logic [2:0] OP_APPEND      = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  localparam logic signed [KeyWidth-1:0] KEY_MIN = {1'b1, {(KeyWidth-1){1'b0}}};
  localparam logic signed [KeyWidth-1:0] KEY_MAX = {1'b0, {(KeyWidth-1){1'b1}}};

  typedef struct packed {
    logic                       valid;
    logic signed [KeyWidth-1:0] key;
    logic [ItemWidth-1:0]       item;
  } entry_t;

  // Broadcast to every cell in the row for the word being applied.
  typedef struct packed {
    logic                       en;
    logic [2:0]                 op;
    logic signed [KeyWidth-1:0] key;
    logic signed [KeyWidth-1:0] new_key;
    logic [ItemWidth-1:0]       item;
  } ctl_t;

endpackage

[hw/rtl/spl_cell.sv]
// ----------------------------------------------------------------------------
// spl_cell: one slot of the sorted priority list
// Holds one entry, decides whether it is the slot an operation acts on,
// and shifts in from its left or right neighbour accordingly.
// ----------------------------------------------------------------------------
module spl_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_cell,
  input  spl_pkg::ctl_t   ctl,
  input  spl_pkg::entry_t left_ent,
  input  spl_pkg::entry_t right_ent,
  input  logic            seen_in,
  output logic            seen_out,
  output logic            hit,
  output spl_pkg::entry_t ent
);

  spl_pkg::entry_t ent_r;
  spl_pkg::entry_t ent_nxt;
  logic            cond;
  logic            ins_op;
  logic            rem_op;

  always_comb begin
    cond = 1'b0;
    case (ctl.op)
      spl_pkg::OP_INSERT: begin
        // The head is passed over when its key equals the new key.
        if (head_cell) begin
          cond = !ent_r.valid || (ent_r.key > ctl.key);
        end else begin
          cond = !ent_r.valid || (ent_r.key >= ctl.key);
        end
      end
      spl_pkg::OP_PREPEND:     cond = 1'b1;
      spl_pkg::OP_APPEND:      cond = !ent_r.valid;
      spl_pkg::OP_REMOVE_HEAD: cond = ent_r.valid;
      spl_pkg::OP_REMOVE_KEY:  cond = ent_r.valid && (ent_r.key == ctl.key);
      default:                 cond = 1'b0;
    endcase
  end

  assign hit      = cond && !seen_in;
  assign seen_out = seen_in || cond;

  assign ins_op = (ctl.op == spl_pkg::OP_INSERT) || (ctl.op == spl_pkg::OP_PREPEND) ||
                  (ctl.op == spl_pkg::OP_APPEND);
  assign rem_op = (ctl.op == spl_pkg::OP_REMOVE_HEAD) || (ctl.op == spl_pkg::OP_REMOVE_KEY);

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.en && ins_op) begin
      if (seen_in) begin
        ent_nxt = left_ent;
      end else if (cond) begin
        ent_nxt.valid = 1'b1;
        ent_nxt.key   = ctl.new_key;
        ent_nxt.item  = ctl.item;
      end
    end else if (ctl.en && rem_op) begin
      if (seen_out) begin
        ent_nxt = right_ent;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r.valid <= ent_nxt.valid;
    end
    ent_r.key  <= ent_nxt.key;
    ent_r.item <= ent_nxt.item;
  end

  assign ent = ent_r;

endmodule

[hw/rtl/sorted_priority_list.sv]
// ----------------------------------------------------------------------------
// sorted_priority_list: bounded list of key and item pairs in ascending order
// A row of cells holds the entries; each word inserts or removes at most one entry.
// ----------------------------------------------------------------------------
//  Channel | Direction | Ports                  | Contents
//  in      | input     | in_tvalid/tready/tuser | opcode; key_in, item_in
//  out     | output    | out_tvalid/tready/tuser| status; key_out, item_out, is_empty
//
//  One word is applied per clock cycle while in_tready is high; the whole row of
//  cells shifts at the edge that takes the word, which also loads the output register.
//  A new word is taken while the output register is empty or being drained.
//  Reset clears all valid bits, so the list starts empty with no clearing pass.
//  A stall on the output holds the result and stops further input words.
// ----------------------------------------------------------------------------
module sorted_priority_list (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // [2:0] opcode
  input  logic [63:0] in_tdata,   // [31:0] key_in, [63:32] item_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic [71:0] out_tdata   // [31:0] key_out, [63:32] item_out, [64] is_empty
);

  localparam int Cap = spl_pkg::Capacity;

  spl_pkg::entry_t ent [Cap];
  spl_pkg::entry_t lft [Cap];
  spl_pkg::entry_t rgt [Cap];
  logic [Cap:0]    seen;
  logic [Cap-1:0]  hit;
  logic [Cap-1:0]  vmask;
  spl_pkg::ctl_t   ctl;

  logic                                in_acc;
  logic                                ins_op;
  logic                                full;
  logic                                empty;
  logic signed [spl_pkg::KeyWidth-1:0] in_key;
  logic signed [spl_pkg::KeyWidth-1:0] tail_key;
  logic signed [spl_pkg::KeyWidth-1:0] sel_key;
  logic [spl_pkg::ItemWidth-1:0]       sel_item;
  logic signed [spl_pkg::KeyWidth-1:0] new_key;

  logic                                out_tvalid_r;
  logic                                out_tvalid_nxt;
  logic [1:0]                          status_r;
  logic [1:0]                          status_nxt;
  logic signed [spl_pkg::KeyWidth-1:0] key_out_r;
  logic signed [spl_pkg::KeyWidth-1:0] key_out_nxt;
  logic [spl_pkg::ItemWidth-1:0]       item_out_r;
  logic [spl_pkg::ItemWidth-1:0]       item_out_nxt;
  logic                                empty_r;
  logic                                empty_nxt;

  assign in_tready = !out_tvalid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign in_key    = in_tdata[31:0];

  assign ins_op = (in_tuser == spl_pkg::OP_INSERT) || (in_tuser == spl_pkg::OP_PREPEND) ||
                  (in_tuser == spl_pkg::OP_APPEND);

  assign full  = ent[Cap-1].valid;
  assign empty = !ent[0].valid;

  // Tail key and removed entry are picked out by one-hot masks over the row.
  always_comb begin
    tail_key = '0;
    sel_key  = '0;
    sel_item = '0;
    for (int i = 0; i < Cap; i++) begin
      if (ent[i].valid && ((i == Cap - 1) || !ent[(i + 1) % Cap].valid)) begin
        tail_key = tail_key | ent[i].key;
      end
      if (hit[i]) begin
        sel_key  = sel_key | ent[i].key;
        sel_item = sel_item | ent[i].item;
      end
    end
  end

  always_comb begin
    new_key = in_key;
    case (in_tuser)
      spl_pkg::OP_PREPEND: begin
        if (empty) begin
          new_key = '0;
        end else if (ent[0].key == spl_pkg::KEY_MIN) begin
          new_key = spl_pkg::KEY_MIN;
        end else begin
          new_key = ent[0].key - 1'b1;
        end
      end
      spl_pkg::OP_APPEND: begin
        if (empty) begin
          new_key = '0;
        end else if (tail_key == spl_pkg::KEY_MAX) begin
          new_key = spl_pkg::KEY_MAX;
        end else begin
          new_key = tail_key + 1'b1;
        end
      end
      default: new_key = in_key;
    endcase
  end

  always_comb begin
    ctl.en      = in_acc && !(ins_op && full);
    ctl.op      = in_tuser;
    ctl.key     = in_key;
    ctl.new_key = new_key;
    ctl.item    = in_tdata[63:32];
  end

  assign seen[0] = 1'b0;

  for (genvar g = 0; g < Cap; g++) begin : g_cell
    if (g == 0) begin : g_left_edge
      assign lft[g] = '0;
    end else begin : g_left
      assign lft[g] = ent[g-1];
    end
    if (g == Cap - 1) begin : g_right_edge
      assign rgt[g] = '0;
    end else begin : g_right
      assign rgt[g] = ent[g+1];
    end

    spl_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .head_cell (g == 0),
      .ctl       (ctl),
      .left_ent  (lft[g]),
      .right_ent (rgt[g]),
      .seen_in   (seen[g]),
      .seen_out  (seen[g+1]),
      .hit       (hit[g]),
      .ent       (ent[g])
    );

    assign vmask[g] = ent[g].valid;
  end

  always_comb begin
    status_nxt   = spl_pkg::ST_OK;
    key_out_nxt  = '0;
    item_out_nxt = '0;
    empty_nxt    = empty;
    if (ins_op) begin
      if (full) begin
        status_nxt = spl_pkg::ST_FULL;
      end else begin
        key_out_nxt = new_key;
        empty_nxt   = 1'b0;
      end
    end else if ((in_tuser == spl_pkg::OP_REMOVE_HEAD) ||
                 (in_tuser == spl_pkg::OP_REMOVE_KEY)) begin
      if (seen[Cap]) begin
        key_out_nxt  = sel_key;
        item_out_nxt = sel_item;
        empty_nxt    = !ent[1].valid;
      end else begin
        status_nxt = spl_pkg::ST_NOT_FOUND;
      end
    end
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (in_acc) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r   <= status_nxt;
      key_out_r  <= key_out_nxt;
      item_out_r <= item_out_nxt;
      empty_r    <= empty_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {7'd0, empty_r, item_out_r, key_out_r};

`ifndef NO_ASSERTIONS
  // Occupied slots always form an unbroken run from the head.
  a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (vmask & (vmask + 1'b1)) == '0)
    else $error("list slots are not packed from the head");

  // At most one cell claims the operation.
  a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit))
    else $error("more than one cell selected");

  a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && ins_op && full |=> $stable(vmask) && (out_tuser == spl_pkg::ST_FULL))
    else $error("insert into a full list changed the list");

  a_remove_head_ok: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_tuser == spl_pkg::OP_REMOVE_HEAD) && !empty
    |=> out_tvalid && (out_tuser == spl_pkg::ST_OK) && !ent[Cap-1].valid)
    else $error("remove head on a non-empty list failed");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (out_tdata[64] == !ent[0].valid))
    else $error("empty flag disagrees with the list");
`endif

endmodule
